// File: rtl/core/tree_ancestor_threshold_query_defines.svh
// Assertion macros used by the tree ancestor threshold query walker.
// Depends on nothing; files that assert include it by bare name.
`ifndef TREE_ANCESTOR_THRESHOLD_QUERY_DEFINES_SVH
`define TREE_ANCESTOR_THRESHOLD_QUERY_DEFINES_SVH
`ifndef SYNTHESIS
`define TATQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TATQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TATQ_ASSERT_IMP(lbl, ante, cons)
`define TATQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/tatq_pkg.sv
// Types and constants for the tree ancestor threshold query block.
// Depends on nothing.
`timescale 1ns / 1ps
package tatq_pkg;

    localparam int NODE_W = 10;
    localparam int VAL_W  = 31;
    localparam int CNT_W  = 11;
    localparam int MEM_W  = 1 + NODE_W + VAL_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } walk_state_t;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] answer;
    } res_t;

endpackage

// File: rtl/core/tatq_walker.sv
// Node store with reset clearing pass and the parent walk sequencer.
// Depends on tatq_pkg and tree_ancestor_threshold_query_defines.svh.
`timescale 1ns / 1ps
`include "tree_ancestor_threshold_query_defines.svh"
module tatq_walker #(
    parameter int MAX_NODES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  tatq_pkg::req_t               req,
    input  logic [tatq_pkg::CNT_W-1:0]   cnt,
    output logic                         ready,
    output tatq_pkg::res_t               res,
    input  logic                         res_take
);
    import tatq_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    logic [MEM_W-1:0] mem [MAX_NODES];
    logic [MEM_W-1:0] rd_reg;

    walk_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] best_reg, best_next;
    logic              found_reg, found_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [VAL_W-1:0]  thr_reg, thr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NODE_W-1:0] ans_reg, ans_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [MEM_W-1:0]  wdata;
    logic              re;

    logic              rd_ok;
    logic [NODE_W-1:0] rd_parent;
    logic [VAL_W-1:0]  rd_strength;
    logic              hit;

    assign rd_ok       = rd_reg[MEM_W-1];
    assign rd_parent   = rd_reg[VAL_W +: NODE_W];
    assign rd_strength = rd_reg[VAL_W-1:0];
    assign hit         = rd_strength >= thr_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[AW'(cur_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        steps_reg <= steps_next;
        node_reg  <= node_next;
        thr_reg   <= thr_next;
        cnt_reg   <= cnt_next;
        ans_reg   <= ans_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        found_next = found_reg;
        steps_next = steps_reg;
        node_next  = node_reg;
        thr_next   = thr_reg;
        cnt_next   = cnt_reg;
        ans_next   = ans_reg;
        we         = 1'b0;
        waddr      = clr_reg;
        wdata      = '0;
        re         = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.cmd == CMD_LOAD)
                    begin
                        if (req.node != '0 && CNT_W'(req.node) < cnt)
                        begin
                            we    = 1'b1;
                            waddr = AW'(req.node);
                            wdata = {1'b1, req.parent, req.value};
                        end
                    end
                    else
                    begin
                        node_next  = req.node;
                        thr_next   = req.value;
                        cnt_next   = cnt;
                        cur_next   = req.node;
                        steps_next = '0;
                        found_next = 1'b0;
                        ans_next   = req.node;
                        if (req.node == '0 || CNT_W'(req.node) >= cnt)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                re         = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!rd_ok || CNT_W'(rd_parent) >= cnt_reg
                    || steps_reg >= cnt_reg - CNT_W'(1))
                begin
                    ans_next   = node_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (hit)
                    begin
                        best_next  = cur_reg;
                        found_next = 1'b1;
                    end
                    if (rd_parent == '0)
                    begin
                        if (thr_reg <= VAL_W'(1))
                        begin
                            ans_next = '0;
                        end
                        else if (hit)
                        begin
                            ans_next = cur_reg;
                        end
                        else if (found_reg)
                        begin
                            ans_next = best_reg;
                        end
                        else
                        begin
                            ans_next = node_reg;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cur_next   = rd_parent;
                        steps_next = steps_reg + CNT_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ready      = state_reg == ST_IDLE;
    assign res.valid  = state_reg == ST_DONE;
    assign res.answer = ans_reg;

    `TATQ_ASSERT_NEXT(a_read_then_eval, state_reg == ST_READ, state_reg == ST_EVAL)
    `TATQ_ASSERT_IMP(a_walk_not_root, state_reg == ST_READ, cur_reg != '0)
    `TATQ_ASSERT_IMP(a_steps_bounded, state_reg == ST_EVAL, steps_reg < cnt_reg)

endmodule

// File: rtl/core/tree_ancestor_threshold_query.sv
// Top level of the tree ancestor threshold query block: node count register,
// input handshake and output register. Depends on tatq_pkg and tatq_walker.
//
//   channel   signals                          direction
//   input     in_valid/in_stall, cmd..value    into block
//   output    out_valid/out_stall, answer_node out of block
//   config    cfg_we, cfg_data                 into block
//
// A load word is written to the node store as it is taken. A query reads one node
// at a time on the way to the root, through the single read port of the node
// store. Its answer passes into the output register once that register is free.
// After reset a clearing pass writes every node store entry before input is taken.
// The output register lets a new word be accepted while a result waits.
`timescale 1ns / 1ps
module tree_ancestor_threshold_query #(
    parameter int MAX_NODES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [tatq_pkg::NODE_W-1:0]   node,
    input  logic [tatq_pkg::NODE_W-1:0]   parent,
    input  logic [tatq_pkg::VAL_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tatq_pkg::NODE_W-1:0]   answer_node,
    input  logic                          cfg_we,
    input  logic [tatq_pkg::CNT_W-1:0]    cfg_data
);
    import tatq_pkg::*;

    logic [CNT_W-1:0]  node_count_reg;
    logic [CNT_W-1:0]  cnt;
    logic              ready;
    logic              start;
    logic              take;
    req_t              req;
    res_t              res;
    logic              out_valid_reg, out_valid_next;
    logic [NODE_W-1:0] answer_reg, answer_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        answer_reg <= answer_next;
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            cnt = CNT_W'(1);
        end
        else if (32'(node_count_reg) > MAX_NODES)
        begin
            cnt = CNT_W'(MAX_NODES);
        end
        else
        begin
            cnt = node_count_reg;
        end
    end

    assign req.cmd    = cmd;
    assign req.node   = node;
    assign req.parent = parent;
    assign req.value  = value;
    assign in_stall   = !ready;
    assign start      = in_valid && ready;
    assign take       = res.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        answer_next    = answer_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            answer_next    = res.answer;
        end
    end

    assign out_valid   = out_valid_reg;
    assign answer_node = answer_reg;

    tatq_walker #(
        .MAX_NODES(MAX_NODES)
    ) u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .cnt      (cnt),
        .ready    (ready),
        .res      (res),
        .res_take (take)
    );

endmodule
